// ===== rtl/core/aea_pkg.sv =====
// Shared types, opcodes and defaults for the array element ALU.
`timescale 1ns / 1ps
package aea_pkg;

  // Element width default and request queue depth
  localparam int ELEM_BITS_DEFAULT   = 16;
  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam int FIELD_BITS          = 16;

  // Opcodes as carried in the request
  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_DIV   = 4'd3,
    OP_GT    = 4'd4,
    OP_LT    = 4'd5,
    OP_EQ    = 4'd6,
    OP_FLIP  = 4'd7,
    OP_AND   = 4'd8,
    OP_OR    = 4'd9,
    OP_XOR   = 4'd10,
    OP_NOT   = 4'd11,
    OP_COPY  = 4'd12,
    OP_CLEAR = 4'd13,
    OP_SQRT  = 4'd14
  } op_t;

  // Which unit produces the final value
  typedef enum logic [1:0] {
    KIND_ALU  = 2'd0,
    KIND_DIV  = 2'd1,
    KIND_SQRT = 2'd2
  } kind_t;

  // Request payload
  typedef struct packed {
    logic [3:0]            opcode;
    logic [FIELD_BITS-1:0] elem_a;
    logic [FIELD_BITS-1:0] elem_b;
    logic [FIELD_BITS-1:0] scalar;
  } cmd_t;

  // Result payload
  typedef struct packed {
    logic [FIELD_BITS-1:0] result;
    logic                  div_zero;
  } res_t;

  // Classified request held in the queue
  typedef struct packed {
    op_t                   op;
    kind_t                 kind;
    logic                  dz;
    logic [FIELD_BITS-1:0] a;
    logic [FIELD_BITS-1:0] b;
    logic [FIELD_BITS-1:0] s;
  } entry_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

endpackage

// ===== rtl/core/aea_front.sv =====
// Front end: accepts requests, decodes and classifies them into queue entries.
`timescale 1ns / 1ps
module aea_front
  import aea_pkg::*;
#(
  parameter int ELEM_BITS = ELEM_BITS_DEFAULT
) (
  input  logic   cmd_valid,
  output logic   cmd_stall,
  input  cmd_t   cmd,
  input  qstat_t qstat,
  output logic   push,
  output entry_t entry
);

  localparam int W = ELEM_BITS;

  logic [W+FIELD_BITS-1:0] s_ext;
  logic [W-1:0]            s_w;
  op_t                     op;

  assign s_ext = {{W{1'b0}}, cmd.scalar};
  assign s_w   = s_ext[W-1:0];
  assign op    = op_t'(cmd.opcode);

  // Handshake into the queue
  assign cmd_stall = qstat.full;
  assign push      = cmd_valid && !qstat.full;

  // Classify: divider, root unit or plain ALU
  always_comb begin
    entry.op   = op;
    entry.a    = cmd.elem_a;
    entry.b    = cmd.elem_b;
    entry.s    = cmd.scalar;
    entry.dz   = 1'b0;
    entry.kind = KIND_ALU;
    case (op)
      OP_DIV: begin
        entry.kind = KIND_DIV;
        entry.dz   = (s_w == '0);
      end
      OP_SQRT: begin
        entry.kind = KIND_SQRT;
      end
      default: begin
        entry.kind = KIND_ALU;
      end
    endcase
  end

endmodule

// ===== rtl/core/aea_queue.sv =====
// Short FIFO of classified requests between front and back.
`timescale 1ns / 1ps
module aea_queue
  import aea_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t din,
  input  logic   pop,
  output entry_t head,
  output qstat_t qstat
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = PW + 1;

  entry_t        slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head        = slots[rd_ptr];
  assign qstat.empty = (count == '0);
  assign qstat.full  = (count == CW'(QUEUE_DEPTH));

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  // Pointers wrap at the last slot; fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/aea_back.sv =====
// Back end: ALU, pipelined restoring divider and root unit, result register.
`timescale 1ns / 1ps
module aea_back
  import aea_pkg::*;
#(
  parameter int ELEM_BITS = ELEM_BITS_DEFAULT
) (
  input  logic   clk,
  input  logic   rst,
  input  entry_t head,
  input  qstat_t qstat,
  output logic   pop,
  output logic   res_valid,
  input  logic   res_stall,
  output res_t   res
);

  localparam int W  = ELEM_BITS;
  localparam int D  = W;            // one quotient bit per stage
  localparam int NR = (W + 1) / 2;  // root digits
  localparam int SP = 2 * NR;

  // Pipeline advances whenever the result register can take a value
  logic en;
  assign en  = !res_valid || !res_stall;
  assign pop = en && !qstat.empty;

  // Operands masked to the element width
  logic [W+FIELD_BITS-1:0] a_ext, b_ext, s_ext;
  logic [W-1:0]            a0, b0, s0;
  logic [2*W-1:0]          prod;
  logic [W-1:0]            alu0;

  assign a_ext = {{W{1'b0}}, head.a};
  assign b_ext = {{W{1'b0}}, head.b};
  assign s_ext = {{W{1'b0}}, head.s};
  assign a0    = a_ext[W-1:0];
  assign b0    = b_ext[W-1:0];
  assign s0    = s_ext[W-1:0];
  assign prod  = {{W{1'b0}}, a0} * {{W{1'b0}}, s0};

  // Combinational ALU operations
  always_comb begin
    case (head.op)
      OP_ADD:   alu0 = a0 + s0;
      OP_SUB:   alu0 = (a0 >= s0) ? (a0 - s0) : '0;
      OP_MUL:   alu0 = prod[W-1:0];
      OP_GT:    alu0 = {{(W-1){1'b0}}, (a0 > s0)};
      OP_LT:    alu0 = {{(W-1){1'b0}}, (a0 < s0)};
      OP_EQ:    alu0 = {{(W-1){1'b0}}, (a0 == s0)};
      OP_FLIP:  alu0 = a0 ^ W'(1);
      OP_AND:   alu0 = b0 & a0;
      OP_OR:    alu0 = b0 | a0;
      OP_XOR:   alu0 = b0 ^ a0;
      OP_NOT:   alu0 = ~a0;
      OP_COPY:  alu0 = a0;
      default:  alu0 = '0;
    endcase
  end

  // Stage registers
  logic          r_v    [D];
  kind_t         r_kind [D];
  logic          r_dz   [D];
  logic [W-1:0]  r_a    [D];
  logic [W-1:0]  r_s    [D];
  logic [W-1:0]  r_rem  [D];
  logic [W-1:0]  r_quo  [D];
  logic [NR+1:0] r_srem [D];
  logic [NR-1:0] r_root [D];
  logic [W-1:0]  r_alu  [D];

  // Stage next values
  logic          n_v    [D];
  kind_t         n_kind [D];
  logic          n_dz   [D];
  logic [W-1:0]  n_a    [D];
  logic [W-1:0]  n_s    [D];
  logic [W-1:0]  n_rem  [D];
  logic [W-1:0]  n_quo  [D];
  logic [NR+1:0] n_srem [D];
  logic [NR-1:0] n_root [D];
  logic [W-1:0]  n_alu  [D];

  genvar k;
  generate
    for (k = 0; k < D; k++) begin : g_stage
      logic          i_v;
      kind_t         i_kind;
      logic          i_dz;
      logic [W-1:0]  i_a, i_s, i_rem, i_quo, i_alu;
      logic [NR+1:0] i_srem;
      logic [NR-1:0] i_root;
      logic [W:0]    d_sh;
      logic          d_ge;
      logic [SP+W-1:0] sp_ext;
      logic [SP-1:0]   sp;
      logic [NR+1:0] srem_nx;
      logic [NR-1:0] root_nx;

      // Stage input: queue head for the first stage
      if (k == 0) begin : g_first
        assign i_v    = !qstat.empty;
        assign i_kind = head.kind;
        assign i_dz   = head.dz;
        assign i_a    = a0;
        assign i_s    = s0;
        assign i_rem  = '0;
        assign i_quo  = '0;
        assign i_srem = '0;
        assign i_root = '0;
        assign i_alu  = alu0;
      end else begin : g_next
        assign i_v    = r_v[k-1];
        assign i_kind = r_kind[k-1];
        assign i_dz   = r_dz[k-1];
        assign i_a    = r_a[k-1];
        assign i_s    = r_s[k-1];
        assign i_rem  = r_rem[k-1];
        assign i_quo  = r_quo[k-1];
        assign i_srem = r_srem[k-1];
        assign i_root = r_root[k-1];
        assign i_alu  = r_alu[k-1];
      end

      // Divider step on quotient bit W-1-k
      assign d_sh = {i_rem, i_a[W-1-k]};
      assign d_ge = (d_sh >= {1'b0, i_s});

      assign sp_ext = {{SP{1'b0}}, i_s};
      assign sp     = sp_ext[SP-1:0];

      // Root step on one digit pair, only in the first NR stages
      if (k < NR) begin : g_root
        logic [NR+1:0] q_sh;
        logic [NR+1:0] q_trial;
        logic          q_ge;
        assign q_sh    = {i_srem[NR-1:0], sp[2*(NR-1-k) +: 2]};
        assign q_trial = {i_root, 2'b01};
        assign q_ge    = (q_sh >= q_trial);
        assign srem_nx = q_ge ? (q_sh - q_trial) : q_sh;
        assign root_nx = {i_root[NR-2:0], q_ge};
      end else begin : g_root_pass
        assign srem_nx = i_srem;
        assign root_nx = i_root;
      end

      always_comb begin
        n_v[k]    = i_v;
        n_kind[k] = i_kind;
        n_dz[k]   = i_dz;
        n_a[k]    = i_a;
        n_s[k]    = i_s;
        n_alu[k]  = i_alu;
        n_rem[k]  = d_ge ? W'(d_sh - {1'b0, i_s}) : d_sh[W-1:0];
        n_quo[k]  = i_quo;
        n_quo[k][W-1-k] = d_ge;
        n_srem[k] = srem_nx;
        n_root[k] = root_nx;
      end

      // Stage register
      always_ff @(posedge clk) begin
        if (rst) begin
          r_v[k] <= 1'b0;
        end else if (en) begin
          r_v[k] <= n_v[k];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          r_kind[k] <= n_kind[k];
          r_dz[k]   <= n_dz[k];
          r_a[k]    <= n_a[k];
          r_s[k]    <= n_s[k];
          r_rem[k]  <= n_rem[k];
          r_quo[k]  <= n_quo[k];
          r_srem[k] <= n_srem[k];
          r_root[k] <= n_root[k];
          r_alu[k]  <= n_alu[k];
        end
      end
    end
  endgenerate

  // Final select from the last stage
  logic [W-1:0]            fin;
  logic [W+FIELD_BITS-1:0] fin_ext;

  always_comb begin
    case (r_kind[D-1])
      KIND_DIV:  fin = r_dz[D-1] ? '0 : r_quo[D-1];
      KIND_SQRT: fin = {{(W-NR){1'b0}}, r_root[D-1]};
      default:   fin = r_alu[D-1];
    endcase
  end

  assign fin_ext = {{FIELD_BITS{1'b0}}, fin};

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= r_v[D-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.result   <= fin_ext[FIELD_BITS-1:0];
      res.div_zero <= r_dz[D-1] && (r_kind[D-1] == KIND_DIV);
    end
  end

endmodule

// ===== rtl/core/array_element_alu.sv =====
// Array element ALU: one opcode, two elements and a scalar in, one 16-bit
// result out. Requests are classified by the front end and wait in a short
// queue (QUEUE_DEPTH entries) ahead of the execution pipeline, which takes
// one request per cycle and returns one result per cycle when the output
// is not stalled. Every operation goes through the same pipeline, whose
// length is set by the restoring divider at one quotient bit per stage:
// a request passes from the queue through the stage registers into the
// result register. The root unit works one digit pair per stage inside
// the same stages. Division by zero returns 0 with div_zero set.
`timescale 1ns / 1ps
module array_element_alu
  import aea_pkg::*;
#(
  parameter int ELEM_BITS   = ELEM_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  qstat_t qstat;
  entry_t entry;
  entry_t head;
  logic   push;
  logic   pop;

  // Decode and classify
  aea_front #(
    .ELEM_BITS (ELEM_BITS)
  ) u_front (
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .qstat     (qstat),
    .push      (push),
    .entry     (entry)
  );

  // Decoupling queue
  aea_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (entry),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  // Execution pipeline
  aea_back #(
    .ELEM_BITS (ELEM_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
